// ===== hw/rtl/wmv_pkg.sv =====
// ----------------------------------------------------------------------------
// wmv_pkg: shared types and constants
// Field widths, fixed-point formats, register map and sequencer states of the
// gated Welford mean and variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmv_pkg;

    localparam int SAMPLE_W = 32;            // latency sample, whole cycles
    localparam int FRAC_W   = 16;            // fraction bits of the mean
    localparam int MEAN_W   = SAMPLE_W + FRAC_W;
    localparam int M2_W     = 62;
    localparam int COUNT_W  = 32;            // width of the count fields
    localparam int PROD_W   = 64;            // product bits kept after the shift
    localparam int PROD_SHIFT = 2 * MEAN_W - PROD_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam logic [M2_W-1:0] M2_MAX = {M2_W{1'b1}};

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_OUTLIER_LIMIT = '0;
    localparam logic [SAMPLE_W-1:0]   LIMIT_RESET = 32'd100000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic {
        ACC_TOTAL,
        ACC_KEPT
    } t_acc_sel;

endpackage

`default_nettype wire

// ===== hw/rtl/wmv_div.sv =====
// ----------------------------------------------------------------------------
// wmv_div: radix-2 restoring divider
// Divides an unsigned mean-width magnitude by an unsigned count, one quotient
// bit per cycle. The quotient is truncated and valid from the done pulse on.
// ----------------------------------------------------------------------------
`default_nettype none

module wmv_div #(
    parameter int DIVISOR_W = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wmv_pkg::MEAN_W-1:0]  i_dividend,
    input  wire logic [DIVISOR_W-1:0]        i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [wmv_pkg::MEAN_W-1:0]       o_quotient
);

    localparam int QW    = wmv_pkg::MEAN_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

    logic [DIVISOR_W-1:0] r_rem;
    logic [QW-1:0]        r_quo;
    logic [DIVISOR_W-1:0] r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 take;

    // The dividend shifts out of the top of r_quo while quotient bits enter
    // at the bottom.
    always_comb begin
        shifted = {r_rem, r_quo[QW-1]};
        diff    = shifted - {1'b0, r_div};
        take    = shifted >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            r_quo <= {r_quo[QW-2:0], take};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/wmv_mul.sv =====
// ----------------------------------------------------------------------------
// wmv_mul: sequential magnitude multiplier
// Multiplies two mean-width magnitudes with one half-width multiplier over
// four partial products and returns the product shifted right by 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wmv_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wmv_pkg::MEAN_W-1:0]  i_a,
    input  wire logic [wmv_pkg::MEAN_W-1:0]  i_b,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [wmv_pkg::PROD_W-1:0]       o_product
);

    localparam int W  = wmv_pkg::MEAN_W;
    localparam int HW = W / 2;
    localparam int PW = 2 * W;

    logic [W-1:0]    r_a;
    logic [W-1:0]    r_b;
    logic [1:0]      r_step;
    logic            r_issue;
    logic [2*HW-1:0] r_pp;
    logic [1:0]      r_pp_idx;
    logic            r_pp_valid;
    logic [PW-1:0]   r_acc;
    logic            r_done;

    logic [HW-1:0]   a_half;
    logic [HW-1:0]   b_half;
    logic [PW-1:0]   pp_aligned;

    // Step bit 0 picks the half of a, bit 1 the half of b.
    always_comb begin
        a_half = r_step[0] ? r_a[W-1:HW] : r_a[HW-1:0];
        b_half = r_step[1] ? r_b[W-1:HW] : r_b[HW-1:0];
        unique case (r_pp_idx)
            2'd0:       pp_aligned = PW'(r_pp);
            2'd1, 2'd2: pp_aligned = PW'(r_pp) << HW;
            default:    pp_aligned = PW'(r_pp) << (2 * HW);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= 1'b0;
            r_step     <= '0;
            r_pp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_pp_valid <= r_issue;
            r_done     <= r_pp_valid && (r_pp_idx == 2'd3);
            if (i_start) begin
                r_issue <= 1'b1;
                r_step  <= '0;
            end else if (r_issue) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_issue <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_pp_valid) begin
            r_acc <= r_acc + pp_aligned;
        end
        r_pp     <= a_half * b_half;
        r_pp_idx <= r_step;
    end

    assign o_busy    = r_issue | r_pp_valid;
    assign o_done    = r_done;
    assign o_product = r_acc[PW-1:wmv_pkg::PROD_SHIFT];

endmodule

`default_nettype wire

// ===== hw/rtl/welford_mean_variance_gated.sv =====
// ----------------------------------------------------------------------------
// welford_mean_variance_gated: online mean and variance of latency samples
// Keeps one Welford accumulator over all samples and one over the samples
// below a programmable outlier limit, with a shared divider and multiplier.
// ----------------------------------------------------------------------------
// Usage:
// A sample beat enters on i_in_valid/o_in_stall with i_sample. Each sample
// produces exactly one result beat on o_out_valid/i_out_stall carrying the
// count, Q32.16 mean and M2 of both accumulators and the inlier flag.
// Each accumulator update runs the 48-step radix-2 divider and then the
// four-step multiplier. A result beat is loaded after the total update for
// an outlier and after both updates for an inlier; the next sample can be
// taken in the cycle after the load. o_in_stall is high while a sample is
// being worked on. The result sits in an output register; a stalled
// receiver does not block acceptance of the next sample, which waits only
// at the point where its own result would overwrite a beat that has not
// been taken. Reset clears both accumulators and sets the outlier limit to
// 100000. The user writes the limit over the APB port at byte address 0
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module welford_mean_variance_gated #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wmv_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [wmv_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [wmv_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,
    // Sample channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [wmv_pkg::SAMPLE_W-1:0]        i_sample,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [wmv_pkg::COUNT_W-1:0]         o_all_count,
    output logic      [wmv_pkg::MEAN_W-1:0]          o_all_mean,
    output logic      [wmv_pkg::M2_W-1:0]            o_all_m2,
    output logic      [wmv_pkg::COUNT_W-1:0]         o_inlier_count,
    output logic      [wmv_pkg::MEAN_W-1:0]          o_inlier_mean,
    output logic      [wmv_pkg::M2_W-1:0]            o_inlier_m2,
    output logic                                     o_is_inlier
);

    localparam int CNT_W = (COUNT_BITS >= wmv_pkg::COUNT_W) ? wmv_pkg::COUNT_W : COUNT_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int MW = wmv_pkg::MEAN_W;

    wmv_pkg::t_state   r_state, n_state;
    wmv_pkg::t_acc_sel r_phase;

    logic [wmv_pkg::SAMPLE_W-1:0] r_limit;
    logic [wmv_pkg::SAMPLE_W-1:0] r_sample;
    logic                         r_inlier;

    logic [CNT_W-1:0]             r_tot_count, r_kept_count;
    logic [MW-1:0]                r_tot_mean, r_kept_mean;
    logic [wmv_pkg::M2_W-1:0]     r_tot_m2, r_kept_m2;

    logic [MW-1:0]                r_mag;
    logic                         r_up;
    logic [CNT_W-1:0]             r_n;
    logic [MW-1:0]                r_newmean;
    logic                         r_out_valid;

    logic                         in_accept;
    logic                         div_start, mul_start, acc_wr, out_load;
    logic                         div_busy, div_done, mul_busy, mul_done;
    logic [MW-1:0]                div_quo;
    logic [wmv_pkg::PROD_W-1:0]   mul_prod;

    logic [CNT_W-1:0]             sel_count;
    logic [MW-1:0]                sel_mean;
    logic [wmv_pkg::M2_W-1:0]     sel_m2;
    logic [MW-1:0]                x;
    logic                         up;
    logic [MW-1:0]                mag;
    logic [CNT_W-1:0]             n_count;
    logic [MW-1:0]                mag_new;
    logic [MW-1:0]                newmean;
    logic [wmv_pkg::SUM_W-1:0]    m2_sum;
    logic [wmv_pkg::M2_W-1:0]     m2_next;
    logic                         cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[wmv_pkg::APB_ADDR_W-1:2] == wmv_pkg::REG_OUTLIER_LIMIT);

    always_comb begin
        if (paddr[wmv_pkg::APB_ADDR_W-1:2] == wmv_pkg::REG_OUTLIER_LIMIT) begin
            prdata = r_limit;
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= wmv_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            r_limit <= pwdata;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_accept = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        acc_wr    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            wmv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    in_accept = 1'b1;
                    n_state   = wmv_pkg::S_PREP;
                end
            end
            wmv_pkg::S_PREP: begin
                div_start = 1'b1;
                n_state   = wmv_pkg::S_DIV;
            end
            wmv_pkg::S_DIV: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = wmv_pkg::S_MUL;
                end
            end
            wmv_pkg::S_MUL: begin
                if (mul_done) begin
                    acc_wr = 1'b1;
                    if (r_phase == wmv_pkg::ACC_TOTAL && r_inlier) begin
                        n_state = wmv_pkg::S_PREP;
                    end else begin
                        n_state = wmv_pkg::S_DONE;
                    end
                end
            end
            wmv_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = wmv_pkg::S_IDLE;
                end
            end
            default: n_state = wmv_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != wmv_pkg::S_IDLE);

    // ---------------- datapath ----------------
    always_comb begin
        if (r_phase == wmv_pkg::ACC_TOTAL) begin
            sel_count = r_tot_count;
            sel_mean  = r_tot_mean;
            sel_m2    = r_tot_m2;
        end else begin
            sel_count = r_kept_count;
            sel_mean  = r_kept_mean;
            sel_m2    = r_kept_m2;
        end
        x       = {r_sample, {wmv_pkg::FRAC_W{1'b0}}};
        up      = x >= sel_mean;
        mag     = up ? (x - sel_mean) : (sel_mean - x);
        n_count = (sel_count == CNT_MAX) ? sel_count : (sel_count + CNT_W'(1));
        // The new deviation has the old one's sign, so only magnitudes move.
        mag_new = r_mag - div_quo;
        newmean = r_up ? (sel_mean + div_quo) : (sel_mean - div_quo);
        m2_sum  = {{(wmv_pkg::SUM_W - wmv_pkg::M2_W){1'b0}}, sel_m2}
                  + {1'b0, mul_prod};
        if (m2_sum > wmv_pkg::SUM_W'(wmv_pkg::M2_MAX)) begin
            m2_next = wmv_pkg::M2_MAX;
        end else begin
            m2_next = m2_sum[wmv_pkg::M2_W-1:0];
        end
    end

    wmv_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_divisor  (n_count),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    wmv_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_mag),
        .i_b       (mag_new),
        .o_busy    (mul_busy),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
            r_inlier <= i_sample < r_limit;
        end
        if (div_start) begin
            r_mag <= mag;
            r_up  <= up;
            r_n   <= n_count;
        end
        if (mul_start) begin
            r_newmean <= newmean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wmv_pkg::ACC_TOTAL;
            r_tot_count  <= '0;
            r_tot_mean   <= '0;
            r_tot_m2     <= '0;
            r_kept_count <= '0;
            r_kept_mean  <= '0;
            r_kept_m2    <= '0;
        end else begin
            if (in_accept) begin
                r_phase <= wmv_pkg::ACC_TOTAL;
            end else if (acc_wr) begin
                r_phase <= wmv_pkg::ACC_KEPT;
            end
            if (acc_wr && r_phase == wmv_pkg::ACC_TOTAL) begin
                r_tot_count <= r_n;
                r_tot_mean  <= r_newmean;
                r_tot_m2    <= m2_next;
            end
            if (acc_wr && r_phase == wmv_pkg::ACC_KEPT) begin
                r_kept_count <= r_n;
                r_kept_mean  <= r_newmean;
                r_kept_m2    <= m2_next;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_all_count    <= wmv_pkg::COUNT_W'(r_tot_count);
            o_all_mean     <= r_tot_mean;
            o_all_m2       <= r_tot_m2;
            o_inlier_count <= wmv_pkg::COUNT_W'(r_kept_count);
            o_inlier_mean  <= r_kept_mean;
            o_inlier_m2    <= r_kept_m2;
            o_is_inlier    <= r_inlier;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------- assertions ----------------
    a_kept_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= r_tot_count)
        else $error("inlier count exceeds total count");

    a_m2_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_wr && r_phase == wmv_pkg::ACC_TOTAL) |=> r_tot_m2 >= $past(r_tot_m2))
        else $error("total M2 decreased on an update");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == wmv_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!div_busy && !mul_busy))
        else $error("arithmetic unit busy while the block takes samples");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result beat not presented after load");

endmodule

`default_nettype wire
